// ===== src/route_longest_prefix_lookup_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the route lookup block.
// Every use is checked on the rising edge of i_clk and is off while reset is
// held.
// ----------------------------------------------------------------------------
`ifndef ROUTE_LONGEST_PREFIX_LOOKUP_ASSERT_SVH
`define ROUTE_LONGEST_PREFIX_LOOKUP_ASSERT_SVH

// The property must hold at every clock edge outside reset.
`define RLPM_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error(msg);

// The expression must never be true at a clock edge outside reset.
`define RLPM_ASSERT_NEVER(label, expr, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) !(expr)) \
        else $error(msg);

`endif

// ===== src/rlpm_pkg.sv =====
// ----------------------------------------------------------------------------
// rlpm_pkg
// Types and constants shared by the longest prefix match route lookup.
// ----------------------------------------------------------------------------
package rlpm_pkg;

    localparam int TABLE_DEPTH = 1024;
    localparam int NUM_PORTS   = 16;
    localparam int ADDR_W      = $clog2(TABLE_DEPTH);
    localparam int COUNT_W     = 11;
    localparam int INDEX_W     = 10;
    localparam int PORT_W      = $clog2(NUM_PORTS);
    localparam int TTL_W       = 8;
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    localparam logic CMD_WRITE  = 1'b0;
    localparam logic CMD_LOOKUP = 1'b1;

    typedef enum logic [1:0] {
        ST_FORWARD = 2'd0,
        ST_EXPIRED = 2'd1,
        ST_NOROUTE = 2'd2,
        ST_WRITTEN = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        OP_WRITE   = 2'd0,
        OP_EXPIRED = 2'd1,
        OP_LOOKUP  = 2'd2
    } t_op;

    typedef struct packed {
        logic               cmd;
        logic [INDEX_W-1:0] entry_index;
        logic [31:0]        route_prefix_in;
        logic [31:0]        route_mask_in;
        logic [31:0]        next_hop_in;
        logic [PORT_W-1:0]  port_in;
        logic [31:0]        dest_addr;
        logic [TTL_W-1:0]   ttl_in;
    } t_item;

    typedef struct packed {
        logic [1:0]        status;
        logic [31:0]       next_hop_out;
        logic [PORT_W-1:0] port_out;
        logic [TTL_W-1:0]  ttl_out;
    } t_result;

    typedef struct packed {
        logic [31:0]       prefix;
        logic [31:0]       mask;
        logic [31:0]       hop;
        logic [PORT_W-1:0] port;
    } t_route;

    // One classified item as it waits between the front and the back.
    typedef struct packed {
        t_op                op;
        logic [INDEX_W-1:0] index;
        t_route             route;
        logic [31:0]        dest;
        logic [TTL_W-1:0]   ttl;
    } t_job;

endpackage

// ===== src/route_longest_prefix_lookup.sv =====
// A write or an expired TTL is queued at the input, then taken by the back end, which registers its result.
// A lookup scans the first min(route_count, 1024) entries, or reports no route if that is 0.
// The back end takes no new item until the last is through and its result has been popped;
// a scan is paced by the single read port of the route table, which it reads once a cycle.
// Up to 4 items queue at the input while the back end works or a result waits.
// Reset is synchronous, active low: it clears route_count and empties both sides.
// ----------------------------------------------------------------------------
// route_longest_prefix_lookup
// IPv4 longest prefix match forwarding engine over a linearly scanned table.
// ----------------------------------------------------------------------------
module route_longest_prefix_lookup (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          push,
    output logic                          full,
    input  rlpm_pkg::t_item               i_item,
    output logic                          empty,
    input  logic                          pop,
    output rlpm_pkg::t_result             o_result,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [rlpm_pkg::COUNT_W-1:0]  i_cfg_data
);

    logic           job_valid;
    rlpm_pkg::t_job job;
    logic           job_pop;
    logic           out_valid;

    assign o_cfg_ready = 1'b1;
    assign empty       = !out_valid;

    rlpm_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .push        (push),
        .full        (full),
        .i_item      (i_item),
        .o_job_valid (job_valid),
        .o_job       (job),
        .i_job_pop   (job_pop)
    );

    rlpm_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_data  (i_cfg_data),
        .i_job_valid (job_valid),
        .i_job       (job),
        .o_job_pop   (job_pop),
        .i_pop       (pop),
        .o_out_valid (out_valid),
        .o_result    (o_result)
    );

endmodule

// ===== src/rlpm_front.sv =====
// ----------------------------------------------------------------------------
// rlpm_front
// Accepts input beats, classifies each as a table write, an expired TTL or a
// lookup, and holds the classified jobs in a short queue for the back end.
// ----------------------------------------------------------------------------
module rlpm_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            push,
    output logic            full,
    input  rlpm_pkg::t_item i_item,
    output logic            o_job_valid,
    output rlpm_pkg::t_job  o_job,
    input  logic            i_job_pop
);

    rlpm_pkg::t_job                r_queue [rlpm_pkg::QUEUE_DEPTH];
    logic [rlpm_pkg::QPTR_W-1:0]   r_wr_ptr;
    logic [rlpm_pkg::QPTR_W-1:0]   r_rd_ptr;
    logic [rlpm_pkg::QPTR_W:0]     r_count;
    rlpm_pkg::t_job                n_job;
    logic                          do_push;
    logic                          do_pop;

    always_comb begin
        n_job.index       = i_item.entry_index;
        n_job.route.prefix = i_item.route_prefix_in;
        n_job.route.mask   = i_item.route_mask_in;
        n_job.route.hop    = i_item.next_hop_in;
        n_job.route.port   = i_item.port_in;
        n_job.dest        = i_item.dest_addr;
        n_job.ttl         = i_item.ttl_in;
        if (i_item.cmd == rlpm_pkg::CMD_WRITE) begin
            n_job.op = rlpm_pkg::OP_WRITE;
        end else if (i_item.ttl_in <= rlpm_pkg::TTL_W'(1)) begin
            n_job.op = rlpm_pkg::OP_EXPIRED;
        end else begin
            n_job.op = rlpm_pkg::OP_LOOKUP;
        end
    end

    assign full        = (r_count == (rlpm_pkg::QPTR_W+1)'(rlpm_pkg::QUEUE_DEPTH));
    assign o_job_valid = (r_count != '0);
    assign o_job       = r_queue[r_rd_ptr];
    assign do_push     = push && !full;
    assign do_pop      = i_job_pop && o_job_valid;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_queue[r_wr_ptr] <= n_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            case ({do_push, do_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

// ===== src/rlpm_back.sv =====
// ----------------------------------------------------------------------------
// rlpm_back
// Carries out queued jobs: writes route entries into the table memory, reports expired TTLs and
// scans the table one entry per cycle for the longest matching prefix.
// ----------------------------------------------------------------------------
`include "route_longest_prefix_lookup_assert.svh"

module rlpm_back (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_valid,
    input  logic [rlpm_pkg::COUNT_W-1:0]  i_cfg_data,
    input  logic                          i_job_valid,
    input  rlpm_pkg::t_job                i_job,
    output logic                          o_job_pop,
    input  logic                          i_pop,
    output logic                          o_out_valid,
    output rlpm_pkg::t_result             o_result
);

    typedef enum logic {
        S_IDLE,
        S_SCAN
    } t_state;

    rlpm_pkg::t_route                    r_mem [rlpm_pkg::TABLE_DEPTH];
    rlpm_pkg::t_route                    r_rd_data;

    t_state                              r_state;
    logic [rlpm_pkg::COUNT_W-1:0]        r_route_count;
    logic [rlpm_pkg::COUNT_W-1:0]        r_limit;
    logic [rlpm_pkg::COUNT_W-1:0]        r_addr;
    logic                                r_rd_valid;
    logic                                r_rd_last;
    logic [31:0]                         r_dest;
    logic [rlpm_pkg::TTL_W-1:0]          r_ttl;
    logic                                r_found;
    logic [31:0]                         r_best_mask;
    logic [31:0]                         r_best_hop;
    logic [rlpm_pkg::PORT_W-1:0]         r_best_port;
    logic                                r_out_valid;
    rlpm_pkg::t_result                   r_out;

    logic [rlpm_pkg::COUNT_W-1:0]        n_limit;
    logic                                cur_match;
    logic                                cur_better;
    logic                                fin_found;
    logic [31:0]                         fin_hop;
    logic [rlpm_pkg::PORT_W-1:0]         fin_port;

    assign o_job_pop   = (r_state == S_IDLE) && i_job_valid && !r_out_valid;
    assign o_out_valid = r_out_valid;
    assign o_result    = r_out;

    // A count above the table depth scans the whole table.
    assign n_limit = (r_route_count > rlpm_pkg::COUNT_W'(rlpm_pkg::TABLE_DEPTH))
                   ? rlpm_pkg::COUNT_W'(rlpm_pkg::TABLE_DEPTH) : r_route_count;

    // Later entries win ties, hence the greater-or-equal compare.
    assign cur_match  = ((r_dest & r_rd_data.mask) == r_rd_data.prefix);
    assign cur_better = cur_match && (!r_found || (r_rd_data.mask >= r_best_mask));
    assign fin_found  = r_found || cur_match;
    assign fin_hop    = cur_better ? r_rd_data.hop  : r_best_hop;
    assign fin_port   = cur_better ? r_rd_data.port : r_best_port;

    always_ff @(posedge i_clk) begin
        if (o_job_pop && (i_job.op == rlpm_pkg::OP_WRITE)) begin
            r_mem[i_job.index[rlpm_pkg::ADDR_W-1:0]] <= i_job.route;
        end
        r_rd_data <= r_mem[r_addr[rlpm_pkg::ADDR_W-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_route_count <= '0;
            r_rd_valid    <= 1'b0;
            r_out_valid   <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_route_count <= i_cfg_data;
            end
            if (i_pop && r_out_valid) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    r_rd_valid <= 1'b0;
                    if (o_job_pop) begin
                        r_out.next_hop_out <= '0;
                        r_out.port_out     <= '0;
                        r_out.ttl_out      <= '0;
                        case (i_job.op)
                            rlpm_pkg::OP_WRITE: begin
                                r_out.status <= rlpm_pkg::ST_WRITTEN;
                                r_out_valid  <= 1'b1;
                            end
                            rlpm_pkg::OP_LOOKUP: begin
                                if (n_limit == '0) begin
                                    r_out.status <= rlpm_pkg::ST_NOROUTE;
                                    r_out_valid  <= 1'b1;
                                end else begin
                                    r_state <= S_SCAN;
                                    r_limit <= n_limit;
                                    r_addr  <= '0;
                                    r_dest  <= i_job.dest;
                                    r_ttl   <= i_job.ttl;
                                    r_found <= 1'b0;
                                end
                            end
                            default: begin
                                r_out.status <= rlpm_pkg::ST_EXPIRED;
                                r_out_valid  <= 1'b1;
                            end
                        endcase
                    end
                end
                S_SCAN: begin
                    // Issue one read per cycle; its data is registered and compared in the next cycle.
                    if (r_addr < r_limit) begin
                        r_addr     <= r_addr + 1'b1;
                        r_rd_valid <= 1'b1;
                        r_rd_last  <= ((r_addr + 1'b1) == r_limit);
                    end else begin
                        r_rd_valid <= 1'b0;
                    end
                    if (r_rd_valid) begin
                        r_found     <= fin_found;
                        r_best_hop  <= fin_hop;
                        r_best_port <= fin_port;
                        if (cur_better) begin
                            r_best_mask <= r_rd_data.mask;
                        end
                        if (r_rd_last) begin
                            r_state     <= S_IDLE;
                            r_out_valid <= 1'b1;
                            if (fin_found) begin
                                r_out.status       <= rlpm_pkg::ST_FORWARD;
                                r_out.next_hop_out <= fin_hop;
                                r_out.port_out     <= fin_port;
                                r_out.ttl_out      <= r_ttl - 1'b1;
                            end else begin
                                r_out.status       <= rlpm_pkg::ST_NOROUTE;
                                r_out.next_hop_out <= '0;
                                r_out.port_out     <= '0;
                                r_out.ttl_out      <= '0;
                            end
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    `RLPM_ASSERT(a_rd_only_in_scan, r_rd_valid |-> (r_state == S_SCAN),
        "table read data valid outside of a scan")
    `RLPM_ASSERT_NEVER(a_pop_into_full_out, o_job_pop && r_out_valid,
        "job started while a result is still waiting")
    `RLPM_ASSERT(a_result_held, (r_out_valid && !i_pop) |=> r_out_valid,
        "waiting result dropped without a pop")
    `RLPM_ASSERT(a_addr_in_limit, (r_state == S_SCAN) |-> (r_addr <= r_limit),
        "scan address ran past the route count")

endmodule
